// ----- design/pida_pkg.sv -----
// Shared types and codes for the positional insert/delete array.
`default_nettype none

package pida_pkg;

    localparam int POS_W  = 7;
    localparam int WORD_W = 32;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_SET    = 3'd3;
    localparam logic [2:0] OP_APPEND = 3'd4;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BADPOS = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;

    typedef struct packed {
        logic [2:0]              operation;
        logic [POS_W-1:0]        position;
        logic signed [WORD_W-1:0] value;
    } pida_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [1:0]              status;
        logic [POS_W-1:0]        entry_count;
    } pida_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_LAST,
        S_DEL_FIRST,
        S_SHIFT_DOWN,
        S_GET_WAIT,
        S_FINISH
    } pida_state_t;

endpackage

`default_nettype wire

// ----- design/pida_ram.sv -----
// Entry store: one write port and one registered read port.
`default_nettype none

module pida_ram import pida_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic signed [WORD_W-1:0] wdata,
    input  wire logic                     re,
    input  wire logic [AW-1:0]            raddr,
    output logic signed [WORD_W-1:0]      rdata
);

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

    // The shift sequences always read and write different entries.
    a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (we && re) |-> (waddr != raddr))
        else $error("read and write hit the same entry");

endmodule

`default_nettype wire

// ----- design/pida_seq.sv -----
// Sequencer that runs each operation as reads and writes on the entry store.
`default_nettype none

module pida_seq import pida_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    input  wire pida_in_t                 req,
    output logic                          idle,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output pida_out_t                     res,
    output logic                          we,
    output logic [AW-1:0]                 waddr,
    output logic signed [WORD_W-1:0]      wdata,
    output logic                          re,
    output logic [AW-1:0]                 raddr,
    input  wire logic signed [WORD_W-1:0] rdata
);

    localparam int PCW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [AW-1:0] PTR_ONE  = AW'(1);

    pida_state_t              state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [AW-1:0]            ptr_reg, ptr_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic signed [WORD_W-1:0] val_reg, val_next;
    logic signed [WORD_W-1:0] rd_reg, rd_next;
    logic [1:0]               stat_reg, stat_next;

    logic [PCW-1:0] pos_ext;
    logic [PCW-1:0] cnt_ext;
    logic [AW-1:0]  pos_idx;
    logic [AW-1:0]  last_idx;
    logic [CW-1:0]  ptr_plus;
    logic           more_down;

    assign pos_ext   = PCW'(req.position);
    assign cnt_ext   = PCW'(cnt_reg);
    assign pos_idx   = pos_ext[AW-1:0];
    assign last_idx  = AW'(cnt_reg - CNT_ONE);
    assign ptr_plus  = CW'(ptr_reg) + CNT_ONE;
    assign more_down = (ptr_plus < cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        rd_reg   <= rd_next;
        stat_reg <= stat_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        rd_next    = rd_reg;
        stat_next  = stat_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = val_reg;
        re         = 1'b0;
        raddr      = '0;
        idle       = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (req_valid)
                begin
                    val_next   = req.value;
                    pos_next   = pos_idx;
                    rd_next    = '0;
                    stat_next  = STAT_OK;
                    state_next = S_FINISH;
                    case (req.operation)
                        OP_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else if (cnt_reg >= CNT_FULL)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else if (pos_ext == cnt_ext)
                            begin
                                we       = 1'b1;
                                waddr    = pos_idx;
                                wdata    = req.value;
                                cnt_next = cnt_reg + CNT_ONE;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr      = last_idx;
                                ptr_next   = last_idx;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr      = pos_idx;
                                ptr_next   = pos_idx;
                                state_next = S_DEL_FIRST;
                            end
                        end
                        OP_GET:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr      = pos_idx;
                                state_next = S_GET_WAIT;
                            end
                        end
                        OP_SET:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                we    = 1'b1;
                                waddr = pos_idx;
                                wdata = req.value;
                            end
                        end
                        OP_APPEND:
                        begin
                            if (cnt_reg >= CNT_FULL)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                we       = 1'b1;
                                waddr    = cnt_reg[AW-1:0];
                                wdata    = req.value;
                                cnt_next = cnt_reg + CNT_ONE;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                // The word read last cycle moves one place up.
                we    = 1'b1;
                waddr = ptr_reg + PTR_ONE;
                wdata = rdata;
                if (ptr_reg == pos_reg)
                begin
                    state_next = S_INS_LAST;
                end
                else
                begin
                    re       = 1'b1;
                    raddr    = ptr_reg - PTR_ONE;
                    ptr_next = ptr_reg - PTR_ONE;
                end
            end
            S_INS_LAST:
            begin
                we         = 1'b1;
                waddr      = pos_reg;
                wdata      = val_reg;
                cnt_next   = cnt_reg + CNT_ONE;
                state_next = S_FINISH;
            end
            S_DEL_FIRST:
            begin
                rd_next = rdata;
                if (more_down)
                begin
                    re         = 1'b1;
                    raddr      = ptr_reg + PTR_ONE;
                    ptr_next   = ptr_reg + PTR_ONE;
                    state_next = S_SHIFT_DOWN;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_ONE;
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_DOWN:
            begin
                // The word read last cycle moves one place down.
                we    = 1'b1;
                waddr = ptr_reg - PTR_ONE;
                wdata = rdata;
                if (more_down)
                begin
                    re       = 1'b1;
                    raddr    = ptr_reg + PTR_ONE;
                    ptr_next = ptr_reg + PTR_ONE;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_ONE;
                    state_next = S_FINISH;
                end
            end
            S_GET_WAIT:
            begin
                rd_next    = rdata;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    logic [PCW-1:0] cnt_out;
    assign cnt_out         = PCW'(cnt_reg);
    assign res.read_value  = rd_reg;
    assign res.status      = stat_reg;
    assign res.entry_count = cnt_out[POS_W-1:0];

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("entry count above capacity");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + CNT_ONE)
                 || (cnt_reg == $past(cnt_reg) - CNT_ONE))
        else $error("entry count moved by more than one");

    a_down_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_DOWN) |-> (CW'(ptr_reg) < cnt_reg))
        else $error("shift-down pointer beyond the last entry");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |=> $stable(cnt_reg))
        else $error("count changed while a result was waiting");

endmodule

`default_nettype wire

// ----- design/positional_insert_delete_array.sv -----
// Top level of the positional insert/delete array: store, sequencer and result register.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------------------------
//  req     | in        | req_valid, req_stall | operation, position, value (pida_in_t)
//  rsp     | out       | rsp_valid, rsp_stall | read_value, status, entry_count (pida_out_t)
//
// An insert at position p moves the words from p to the tail up one place, last word
// first, then writes the new word; a delete reads the word at p and moves the words above
// it down one place. The single read and single write port of the entry store set the
// pace: a shift moves one word per cycle. Get reads one word; set and append only write.
// Reset clears the entry count and the sequencer; the words in the store are not cleared.
// A finished item waits in the result register while the next item is accepted and run.
// The request side is stalled whenever the sequencer is working on an item.
`default_nettype none

module positional_insert_delete_array import pida_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire pida_in_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output pida_out_t     rsp
);

    // Address width for the store and width for a count that can reach DEPTH.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [WORD_W-1:0] wdata;
    logic                     re;
    logic [AW-1:0]            raddr;
    logic signed [WORD_W-1:0] rdata;

    logic      idle;
    logic      res_valid;
    logic      res_ready;
    pida_out_t res;

    logic      out_valid_reg, out_valid_next;
    pida_out_t out_reg;

    pida_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    pida_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .re        (re),
        .raddr     (raddr),
        .rdata     (rdata)
    );

    // New items are taken only when the sequencer is idle.
    assign req_stall = !idle;

    // The result register takes a new item when it is empty or being drained.
    assign res_ready = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // A result leaves the sequencer only into a free or draining result register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rsp_stall) |-> !(res_valid && res_ready))
        else $error("result register overwritten while stalled");

    // An item is never accepted while the sequencer still holds a result.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> !res_valid)
        else $error("item accepted while a result was pending in the sequencer");

    // Every accepted item leads to a result no sooner than the next cycle.
    a_result_later: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> !idle)
        else $error("sequencer idle right after taking an item");

endmodule

`default_nettype wire

// ----- dv/positional_insert_delete_array_tb.sv -----
// Self-checking testbench for the positional insert/delete array.
`default_nettype none

module positional_insert_delete_array_tb;
    import pida_pkg::*;

    // The list depth of the block under test; the shadow list uses the same figure.
    localparam int LIST_DEPTH = 64;

    // Operation codes 5 to 7 have no meaning; the block must ignore them.
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    // The slowest item is an insert at the head of a 63-entry list.
    // The pause before a phase change and the wait at the end both use the margin below.
    localparam int SETTLE_CYCLES = 80;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    pida_in_t  req;
    logic      rsp_valid;
    logic      rsp_stall;
    pida_out_t rsp;

    // Shadow copy of the list: the words and how many of them are valid.
    logic signed [WORD_W-1:0] shadow_words [LIST_DEPTH];
    int unsigned              shadow_len;

    // Results that accepted items should produce, oldest first.
    pida_out_t pending_results [$];
    int        error_count;

    // When this is low, neither side inserts idle cycles.
    bit idle_on;

    positional_insert_delete_array #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Applies one item to the shadow list and returns the result that the block
    // should give for it. A rejected item leaves the shadow list untouched.
    function automatic pida_out_t apply_list_op(input pida_in_t item);
        pida_out_t   res;
        int unsigned idx;
        res = '0;
        res.status = STAT_OK;
        case (item.operation)
            OP_INSERT:
            begin
                // The position check comes before the full check.
                if (item.position > shadow_len)
                    res.status = STAT_BADPOS;
                else if (shadow_len >= LIST_DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    for (idx = shadow_len; idx > item.position; idx--)
                        shadow_words[idx] = shadow_words[idx - 1];
                    shadow_words[item.position] = item.value;
                    shadow_len++;
                end
            end
            OP_DELETE:
            begin
                if (item.position >= shadow_len)
                    res.status = STAT_BADPOS;
                else
                begin
                    res.read_value = shadow_words[item.position];
                    for (idx = item.position; idx + 1 < shadow_len; idx++)
                        shadow_words[idx] = shadow_words[idx + 1];
                    shadow_len--;
                end
            end
            OP_GET:
            begin
                if (item.position >= shadow_len)
                    res.status = STAT_BADPOS;
                else
                    res.read_value = shadow_words[item.position];
            end
            OP_SET:
            begin
                if (item.position >= shadow_len)
                    res.status = STAT_BADPOS;
                else
                    shadow_words[item.position] = item.value;
            end
            OP_APPEND:
            begin
                if (shadow_len >= LIST_DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    shadow_words[shadow_len] = item.value;
                    shadow_len++;
                end
            end
            default:
            begin
                // Unused codes change nothing and report ok.
            end
        endcase
        res.entry_count = shadow_len[POS_W-1:0];
        return res;
    endfunction

    // Sends one item. The payload changes only at a falling edge after the previous
    // item was taken, and valid is only lowered for a gap, never within the same step
    // in which it is raised again. The expected result is recorded at the rising edge
    // at which the block takes the item, so the shadow list follows the block's order.
    task automatic send_item(input logic [2:0] op, input logic [POS_W-1:0] pos,
                             input logic [WORD_W-1:0] val);
        pida_in_t item;
        item.operation = op;
        item.position  = pos;
        item.value     = val;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        pending_results.push_back(apply_list_op(item));
    endtask

    // Holds the request side idle until every outstanding result has come back,
    // then lets the block settle.
    task automatic wait_for_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Requests on an empty list: everything that needs an entry must be rejected,
    // and an insert beyond the end must be rejected too.
    task automatic test_empty_list();
        send_item(OP_GET, 7'd0, 32'h0000_0001);
        send_item(OP_DELETE, 7'd0, 32'hFFFF_FFFF);
        send_item(OP_SET, 7'd0, 32'h1234_5678);
        send_item(OP_INSERT, 7'd1, 32'h0BAD_0BAD);
    endtask

    // Inserts and deletes at the head, the middle and the tail, the extreme words,
    // off-by-one positions and the unused operation codes.
    task automatic test_list_edges();
        send_item(OP_INSERT, 7'd0, 32'h8000_0000);
        send_item(OP_APPEND, 7'h7F, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 7'd1, 32'hFFFF_FFFF);
        // An insert at the position equal to the count lands at the tail.
        send_item(OP_INSERT, 7'd3, 32'h0000_0000);
        send_item(OP_INSERT, 7'h7F, 32'hDEAD_BEEF);
        send_item(OP_GET, 7'd3, 32'h0);
        send_item(OP_GET, 7'd4, 32'h0);
        send_item(OP_SET, 7'd0, 32'h5555_5555);
        send_item(OP_GET, 7'd0, 32'hAAAA_AAAA);
        // Delete at the position equal to the count is past the last entry.
        send_item(OP_DELETE, 7'd4, 32'h0);
        send_item(OP_DELETE, 7'd1, 32'h0);
        send_item(OP_DELETE, 7'd0, 32'h0);
        send_item(OP_DELETE, 7'd1, 32'h0);
        send_item(OP_UNUSED_FIRST, 7'h7F, 32'hFFFF_FFFF);
        send_item(OP_UNUSED_FIRST + 3'd1, 7'd0, 32'h0000_0000);
        send_item(OP_UNUSED_LAST, 7'h40, 32'h8000_0001);
        send_item(OP_GET, 7'd64, 32'h0);
    endtask

    // Fills the list to capacity, checks that full is reported where it should be
    // and that a bad position still wins over full, then runs the longest shifts.
    task automatic test_full_list();
        while (shadow_len < LIST_DEPTH)
            send_item(OP_APPEND, 7'($urandom), $urandom);
        send_item(OP_APPEND, 7'd0, 32'h1111_1111);
        send_item(OP_INSERT, 7'd64, 32'h2222_2222);
        send_item(OP_INSERT, 7'd65, 32'h3333_3333);
        send_item(OP_INSERT, 7'd0, 32'h4444_4444);
        send_item(OP_GET, 7'd63, 32'h0);
        send_item(OP_SET, 7'd63, 32'h8000_0000);
        send_item(OP_GET, 7'd63, 32'h0);
        send_item(OP_DELETE, 7'd0, 32'h0);
        send_item(OP_INSERT, 7'd0, 32'h7FFF_FFFF);
        send_item(OP_DELETE, 7'd63, 32'h0);
        send_item(OP_GET, 7'd0, 32'h0);
    endtask

    // Random traffic. Most items are well formed so that the list grows, shrinks
    // and reaches full; the rest are bad positions, boundary positions and unused
    // codes. grow_pct sets how often a well-formed item adds an entry.
    task automatic test_random_mix(input int num_items, input int grow_pct);
        int               pick;
        logic [2:0]       op;
        logic [POS_W-1:0] pos;
        logic [WORD_W-1:0] val;
        repeat (num_items)
        begin
            pick = $urandom_range(0, 99);
            val  = $urandom;
            case ($urandom_range(0, 2))
                0:       op = OP_DELETE;
                1:       op = OP_GET;
                default: op = OP_SET;
            endcase
            if (pick < 4)
            begin
                op  = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
                pos = 7'($urandom);
            end
            else if (pick < 10)
            begin
                // A position past the end; the insert case is covered here too.
                if ($urandom_range(0, 3) == 0)
                    op = OP_INSERT;
                pos = 7'($urandom_range(shadow_len + 1, 127));
            end
            else if (pick < 14)
            begin
                // The position equal to the count is just past the last entry.
                pos = 7'(shadow_len);
            end
            else if ($urandom_range(0, 99) < grow_pct)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    op = OP_INSERT;
                    case ($urandom_range(0, 3))
                        0:       pos = 7'd0;
                        1:       pos = 7'(shadow_len);
                        default: pos = 7'($urandom_range(0, shadow_len));
                    endcase
                end
                else
                begin
                    op  = OP_APPEND;
                    pos = 7'($urandom);
                end
            end
            else
            begin
                if (shadow_len == 0)
                    pos = 7'd0;
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       pos = 7'd0;
                        1:       pos = 7'(shadow_len - 1);
                        default: pos = 7'($urandom_range(0, shadow_len - 1));
                    endcase
                end
            end
            send_item(op, pos, val);
        end
    endtask

    // The result side stalls in random bursts while idling is on.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            rsp_stall <= 1'b0;
        end
    end

    // Every result the block hands over is matched against the oldest expectation.
    always @(posedge clk)
    begin
        pida_out_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: read_value %0d status %0d count %0d",
                       rsp.read_value, rsp.status, rsp.entry_count);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, actual %0d",
                           want.read_value, rsp.read_value);
                    error_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, rsp.entry_count);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset once, directed tests, random phases, then the final word.
    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        idle_on     = 1'b1;
        error_count = 0;
        shadow_len  = 0;
        foreach (shadow_words[i])
            shadow_words[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_list_edges();
        test_full_list();
        // The sender holds off here until the block has returned every result.
        wait_for_results();
        // The list is one short of full on entry, so a shrinking phase comes first.
        test_random_mix(150, 35);
        test_random_mix(200, 65);
        wait_for_results();
        // The last stretch runs at full rate with no idling on either side.
        idle_on = 1'b0;
        test_random_mix(200, 50);

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // A hung handshake ends the run here; a correct run needs well under a tenth of this.
    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
